### hdl/fpc_pkg.sv
// ---------------------------------------------------------------------------
// Float placement package
// Shared types, codes and constants for the float placement block.
// ---------------------------------------------------------------------------
package fpc_pkg;

  // Coordinate width: signed fixed point with four fraction bits.
  localparam int CRD_W = 21;
  // Size width: clamped widths and heights are never negative.
  localparam int SZ_W = CRD_W - 1;
  localparam int MAX_FLOATS_DEF = 32;

  localparam logic signed [CRD_W-1:0] CRD_MAX = {1'b0, {(CRD_W-1){1'b1}}};

  typedef logic signed [CRD_W-1:0] crd_t;
  typedef logic signed [CRD_W:0]   crd_wide_t;
  typedef logic [SZ_W-1:0]         size_t;

  typedef enum logic [1:0] {
    CMD_PLACE = 2'd0,
    CMD_BAND  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    SIDE_NONE  = 2'd0,
    SIDE_LEFT  = 2'd1,
    SIDE_RIGHT = 2'd2,
    SIDE_BAD   = 2'd3
  } side_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_LEFT  = 2'd1,
    KIND_RIGHT = 2'd2,
    KIND_BOTH  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PLACE,
    OP_BAND,
    OP_CLEAR
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LIFT,
    ST_BAND,
    ST_TEST,
    ST_NEXT,
    ST_CLEAR,
    ST_STORE,
    ST_OUT
  } state_t;

  // One stored float rectangle.
  typedef struct packed {
    logic signed [CRD_W-1:0] f_left;
    logic signed [CRD_W-1:0] f_top;
    logic signed [CRD_W-1:0] f_right;
    logic signed [CRD_W-1:0] f_bottom;
    logic                    f_is_right;
  } float_ent_t;

endpackage

### hdl/fpc_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ---------------------------------------------------------------------------
module fpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/float_placement_context_top.sv
// ---------------------------------------------------------------------------
// Float placement context
// Table of placed left and right floats with place, band and clearance
// commands, run by a small sequencer over one shared table read port.
// ---------------------------------------------------------------------------
// Usage:
// Commands arrive on the in_ channel; each produces exactly one result
// transfer on the out_ channel. A transfer happens at a rising edge where
// valid is high and stall is low. The block takes one command at a time:
// in_stall is high from the cycle after a command is taken until its result
// has been handed to the output register.
// The time a command takes depends on the number of stored floats N.
// A band query or a clearance query takes one pass over the table; a place
// command takes one pass to lift its top, then a band pass and a test for
// every band it tries, a search pass for the next bottom after each failed
// test, and finally a store state and an output state. Each pass reads the
// float table through its single read port, once per cycle with registered
// data.
// The result sits in an output register, so the next command is accepted
// while a finished result still waits; if the receiver holds out_stall the
// sequencer waits in its final state until the register is free.
// Reset empties the table (count to zero) and clears the lowest bottom;
// the table memory itself is not cleared, as only written entries are read.
// ---------------------------------------------------------------------------
module float_placement_context_top
  import fpc_pkg::*;
#(
  parameter int MAX_FLOATS = MAX_FLOATS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_command,
  input  logic [1:0]              in_side,
  input  logic [1:0]              in_clear_kind,
  input  logic signed [CRD_W-1:0] in_box_width,
  input  logic signed [CRD_W-1:0] in_box_height,
  input  logic signed [CRD_W-1:0] in_y_pos,
  input  logic signed [CRD_W-1:0] in_left_edge,
  input  logic signed [CRD_W-1:0] in_right_edge,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [CRD_W-1:0] out_place_x,
  output logic signed [CRD_W-1:0] out_place_y,
  output logic [SZ_W-1:0]         out_place_width,
  output logic [SZ_W-1:0]         out_place_height,
  output logic signed [CRD_W-1:0] out_band_left,
  output logic signed [CRD_W-1:0] out_band_right,
  output logic signed [CRD_W-1:0] out_clearance_y,
  output logic [SZ_W-1:0]         out_lowest_bottom,
  output logic                    out_table_full
);

  localparam int AW   = (MAX_FLOATS > 1) ? $clog2(MAX_FLOATS) : 1;
  localparam int CNTW = $clog2(MAX_FLOATS + 1);
  localparam int EW   = $bits(float_ent_t);
  localparam logic [CNTW-1:0] MAX_CNT = CNTW'(MAX_FLOATS);

  state_t      state_r, state_nxt;
  op_t         op_r, op_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic [CNTW-1:0] ic_r, ic_nxt;
  logic        pend_r, pend_nxt;
  logic        isr_r, isr_nxt;
  kind_t       kind_r, kind_nxt;
  crd_t        y_r, y_nxt, l_r, l_nxt, r_r, r_nxt;
  crd_t        bl_r, bl_nxt, br_r, br_nxt, x_r, x_nxt;
  crd_t        next_r, next_nxt, cy_r, cy_nxt;
  logic        have_r, have_nxt, full_r, full_nxt;
  size_t       pw_r, pw_nxt, ph_r, ph_nxt;
  size_t       lowest_r, lowest_nxt;

  logic        ov_r, ov_nxt;
  crd_t        o_px_r, o_px_nxt, o_py_r, o_py_nxt;
  size_t       o_pw_r, o_pw_nxt, o_ph_r, o_ph_nxt;
  crd_t        o_bl_r, o_bl_nxt, o_br_r, o_br_nxt, o_cy_r, o_cy_nxt;
  size_t       o_lb_r, o_lb_nxt;
  logic        o_full_r, o_full_nxt;

  logic        ram_we;
  float_ent_t  ram_wdata, rd;
  logic [EW-1:0] ram_rdata;

  // Scan and arithmetic helpers.
  logic        issue, scan_done, overlap, fits, match;
  crd_wide_t   span_end, room, wide, brc_w, xr_w, yb_w, fb_w;
  crd_t        brc, xs, ys;

  fpc_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_FLOATS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (ic_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd = float_ent_t'(ram_rdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      lowest_r <= '0;
      pend_r   <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      lowest_r <= lowest_nxt;
      pend_r   <= pend_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    ic_r     <= ic_nxt;
    isr_r    <= isr_nxt;
    kind_r   <= kind_nxt;
    y_r      <= y_nxt;
    l_r      <= l_nxt;
    r_r      <= r_nxt;
    bl_r     <= bl_nxt;
    br_r     <= br_nxt;
    x_r      <= x_nxt;
    next_r   <= next_nxt;
    cy_r     <= cy_nxt;
    have_r   <= have_nxt;
    full_r   <= full_nxt;
    pw_r     <= pw_nxt;
    ph_r     <= ph_nxt;
    o_px_r   <= o_px_nxt;
    o_py_r   <= o_py_nxt;
    o_pw_r   <= o_pw_nxt;
    o_ph_r   <= o_ph_nxt;
    o_bl_r   <= o_bl_nxt;
    o_br_r   <= o_br_nxt;
    o_cy_r   <= o_cy_nxt;
    o_lb_r   <= o_lb_nxt;
    o_full_r <= o_full_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    count_nxt  = count_r;
    ic_nxt     = ic_r;
    pend_nxt   = 1'b0;
    isr_nxt    = isr_r;
    kind_nxt   = kind_r;
    y_nxt      = y_r;
    l_nxt      = l_r;
    r_nxt      = r_r;
    bl_nxt     = bl_r;
    br_nxt     = br_r;
    x_nxt      = x_r;
    next_nxt   = next_r;
    cy_nxt     = cy_r;
    have_nxt   = have_r;
    full_nxt   = full_r;
    pw_nxt     = pw_r;
    ph_nxt     = ph_r;
    lowest_nxt = lowest_r;
    ov_nxt     = ov_r;
    o_px_nxt   = o_px_r;
    o_py_nxt   = o_py_r;
    o_pw_nxt   = o_pw_r;
    o_ph_nxt   = o_ph_r;
    o_bl_nxt   = o_bl_r;
    o_br_nxt   = o_br_r;
    o_cy_nxt   = o_cy_r;
    o_lb_nxt   = o_lb_r;
    o_full_nxt = o_full_r;
    ram_we     = 1'b0;

    // A scan issues one table read per cycle and consumes the data in the
    // following cycle; it ends once every entry has been issued and consumed.
    issue     = (ic_r < count_r);
    scan_done = !issue && !pend_r;
    span_end  = {y_r[CRD_W-1], y_r} + {2'b00, ph_r};
    overlap   = ($signed({rd.f_top[CRD_W-1], rd.f_top}) < span_end) &&
                (y_r < rd.f_bottom);
    match     = (kind_r == KIND_BOTH) || (kind_r == KIND_LEFT && !rd.f_is_right) ||
                (kind_r == KIND_RIGHT && rd.f_is_right);
    brc       = (br_r < bl_r) ? bl_r : br_r;
    brc_w     = {brc[CRD_W-1], brc} - {2'b00, pw_r};
    wide      = {brc[CRD_W-1], brc} - {bl_r[CRD_W-1], bl_r};
    fits      = (wide >= $signed({2'b00, pw_r}));
    fb_w      = {r_r[CRD_W-1], r_r} - {2'b00, pw_r};
    room      = {in_right_edge[CRD_W-1], in_right_edge} -
                {in_left_edge[CRD_W-1], in_left_edge};
    xr_w      = {x_r[CRD_W-1], x_r} + {2'b00, pw_r};
    yb_w      = {y_r[CRD_W-1], y_r} + {2'b00, ph_r};
    xs        = (xr_w[CRD_W:CRD_W-1] == 2'b01) ? CRD_MAX : xr_w[CRD_W-1:0];
    ys        = (yb_w[CRD_W:CRD_W-1] == 2'b01) ? CRD_MAX : yb_w[CRD_W-1:0];
    ram_wdata = '{f_left: x_r, f_top: y_r, f_right: xs, f_bottom: ys,
                  f_is_right: isr_r};

    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end

    if (issue && state_r != ST_IDLE && state_r != ST_TEST &&
        state_r != ST_STORE && state_r != ST_OUT) begin
      ic_nxt   = ic_r + 1'b1;
      pend_nxt = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        ic_nxt   = '0;
        pend_nxt = 1'b0;
        if (in_valid) begin
          y_nxt    = in_y_pos;
          l_nxt    = in_left_edge;
          r_nxt    = in_right_edge;
          bl_nxt   = in_left_edge;
          br_nxt   = in_right_edge;
          cy_nxt   = in_y_pos;
          kind_nxt = kind_t'(in_clear_kind);
          isr_nxt  = (side_t'(in_side) == SIDE_RIGHT);
          x_nxt    = '0;
          full_nxt = 1'b0;
          ph_nxt   = in_box_height[CRD_W-1] ? '0 : in_box_height[SZ_W-1:0];
          if (in_box_width[CRD_W-1]) begin
            pw_nxt = '0;
          end else if (room[CRD_W]) begin
            pw_nxt = '0;
          end else if ({in_box_width[CRD_W-1], in_box_width} > room) begin
            pw_nxt = room[SZ_W-1:0];
          end else begin
            pw_nxt = in_box_width[SZ_W-1:0];
          end
          case (cmd_t'(in_command))
            CMD_PLACE: begin
              if (side_t'(in_side) == SIDE_LEFT || side_t'(in_side) == SIDE_RIGHT) begin
                op_nxt    = OP_PLACE;
                state_nxt = ST_LIFT;
              end else begin
                op_nxt    = OP_NONE;
                state_nxt = ST_OUT;
              end
            end
            CMD_BAND: begin
              op_nxt    = OP_BAND;
              state_nxt = ST_BAND;
            end
            CMD_CLEAR: begin
              op_nxt    = OP_CLEAR;
              state_nxt = (kind_t'(in_clear_kind) == KIND_NONE) ? ST_OUT : ST_CLEAR;
            end
            default: begin
              op_nxt    = OP_NONE;
              state_nxt = ST_OUT;
            end
          endcase
        end
      end
      ST_LIFT: begin
        if (pend_r && rd.f_top > y_r) begin
          y_nxt = rd.f_top;
        end
        if (scan_done) begin
          ic_nxt    = '0;
          bl_nxt    = l_r;
          br_nxt    = r_r;
          state_nxt = ST_BAND;
        end
      end
      ST_BAND: begin
        if (pend_r && overlap) begin
          if (!rd.f_is_right) begin
            if (rd.f_right > bl_r) bl_nxt = rd.f_right;
          end else begin
            if (rd.f_left < br_r) br_nxt = rd.f_left;
          end
        end
        if (scan_done) begin
          state_nxt = (op_r == OP_PLACE) ? ST_TEST : ST_OUT;
        end
      end
      ST_TEST: begin
        if (fits) begin
          x_nxt     = isr_r ? brc_w[CRD_W-1:0] : bl_r;
          state_nxt = ST_STORE;
        end else begin
          have_nxt  = 1'b0;
          ic_nxt    = '0;
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (pend_r && rd.f_bottom > y_r && (!have_r || rd.f_bottom < next_r)) begin
          next_nxt = rd.f_bottom;
          have_nxt = 1'b1;
        end
        if (scan_done) begin
          ic_nxt = '0;
          if (have_r) begin
            y_nxt     = next_r;
            bl_nxt    = l_r;
            br_nxt    = r_r;
            state_nxt = ST_BAND;
          end else begin
            // No band fits: fall back to the container edge.
            if (isr_r) begin
              x_nxt = (fb_w > $signed({l_r[CRD_W-1], l_r})) ? fb_w[CRD_W-1:0] : l_r;
            end else begin
              x_nxt = l_r;
            end
            state_nxt = ST_STORE;
          end
        end
      end
      ST_CLEAR: begin
        if (pend_r && match && rd.f_bottom > cy_r) begin
          cy_nxt = rd.f_bottom;
        end
        if (scan_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_STORE: begin
        if (count_r >= MAX_CNT) begin
          full_nxt = 1'b1;
        end else begin
          ram_we    = 1'b1;
          count_nxt = count_r + 1'b1;
          if (!ys[CRD_W-1] && ys[SZ_W-1:0] > lowest_r) begin
            lowest_nxt = ys[SZ_W-1:0];
          end
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt     = 1'b1;
          o_px_nxt   = (op_r == OP_PLACE) ? x_r : '0;
          o_py_nxt   = (op_r == OP_PLACE) ? y_r : '0;
          o_pw_nxt   = (op_r == OP_PLACE) ? pw_r : '0;
          o_ph_nxt   = (op_r == OP_PLACE) ? ph_r : '0;
          o_full_nxt = (op_r == OP_PLACE) && full_r;
          o_bl_nxt   = (op_r == OP_BAND) ? bl_r : '0;
          o_br_nxt   = (op_r == OP_BAND) ? brc : '0;
          o_cy_nxt   = (op_r == OP_CLEAR) ? cy_r : '0;
          o_lb_nxt   = lowest_r;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = ov_r;
  assign out_place_x       = o_px_r;
  assign out_place_y       = o_py_r;
  assign out_place_width   = o_pw_r;
  assign out_place_height  = o_ph_r;
  assign out_band_left     = o_bl_r;
  assign out_band_right    = o_br_r;
  assign out_clearance_y   = o_cy_r;
  assign out_lowest_bottom = o_lb_r;
  assign out_table_full    = o_full_r;

  // Every taken command leaves the idle state on the next cycle.
  a_take_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != ST_IDLE))
    else $error("command taken but sequencer stayed idle");

  // The float count never passes the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("float count beyond table depth");

  // A full flag is only reported once the table really is full.
  a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |-> (count_r == MAX_CNT))
    else $error("table full reported with free entries");

  // A reported band is never inverted.
  a_band_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_band_right >= out_band_left))
    else $error("band right edge below left edge");

  // Read data is only pending inside a scan.
  a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == ST_LIFT || state_r == ST_BAND ||
                state_r == ST_NEXT || state_r == ST_CLEAR))
    else $error("table read pending outside a scan");

endmodule
